/* hdl/swm_pkg.sv */
// Shared types and constants of the stack with middle access.
// Request and result beat structs, operation and status codes, tree sizing.
// No dependencies.
package swm_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;
  localparam int TREE_SH   = 3;
  localparam int FANIN     = 1 << TREE_SH;

  typedef enum logic [1:0] {
    FUNC_PUSH     = 2'd0,
    FUNC_POP      = 2'd1,
    FUNC_READ_MID = 2'd2,
    FUNC_DEL_MID  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    func_e                     func;
    logic signed [DATA_W-1:0]  push_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  result_value;
    status_e                   status;
  } out_beat_t;

  typedef struct packed {
    logic push_en;
    logic del_en;
    logic rd_en;
  } cell_ctrl_t;

  function automatic int tree_lvls(input int n);
    int l;
    int c;
    l = 1;
    c = FANIN;
    for (int i = 0; i < 8; i++) begin
      if (c < n) begin
        c = c * FANIN;
        l = l + 1;
      end
    end
    return l;
  endfunction

endpackage

/* hdl/swm_cell.sv */
// One storage cell of the stack row; holds the entry at a fixed position.
// Compares its own position to count, middle and select; uses swm_pkg.
module swm_cell #(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                       clk_i,
  input  swm_pkg::cell_ctrl_t        ctrl_i,
  input  logic [CW-1:0]              n_i,
  input  logic [CW-1:0]              mid_i,
  input  logic [CW-1:0]              sel_i,
  input  logic [swm_pkg::DATA_W-1:0] push_value_i,
  input  logic [swm_pkg::DATA_W-1:0] upper_i,
  output logic [swm_pkg::DATA_W-1:0] data_o,
  output logic [swm_pkg::DATA_W-1:0] rd_o
);

  localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
  localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

  logic [swm_pkg::DATA_W-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push_en && (n_i == MY_IDX)) begin
      data_d = push_value_i;
    end else if (ctrl_i.del_en && (mid_i <= MY_IDX) && (MY_NEXT < n_i)) begin
      data_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (ctrl_i.rd_en && (sel_i == MY_IDX)) ? data_q : '0;

endmodule

/* hdl/swm_or_tree.sv */
// Registered OR tree that gathers the one selected cell value to a root.
// Eight inputs per node, one register level per tree level; uses swm_pkg.
module swm_or_tree #(
  parameter int DEPTH = swm_pkg::DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 cap_i,
  input  logic [DEPTH-1:0][swm_pkg::DATA_W-1:0] leaves_i,
  output logic [swm_pkg::DATA_W-1:0]           root_o
);

  localparam int LVLS   = swm_pkg::tree_lvls(DEPTH);
  localparam int LEAVES = 1 << (swm_pkg::TREE_SH * LVLS);

  logic [LVLS:0][LEAVES-1:0][swm_pkg::DATA_W-1:0] lvl_d, lvl_q;

  always_comb begin
    lvl_d = lvl_q;
    if (cap_i) begin
      for (int j = 0; j < LEAVES; j++) begin
        lvl_d[0][j] = '0;
        if (j < DEPTH) begin
          lvl_d[0][j] = leaves_i[j];
        end
      end
    end
    for (int k = 1; k <= LVLS; k++) begin
      for (int j = 0; j < LEAVES; j++) begin
        lvl_d[k][j] = '0;
        if (j < (LEAVES >> (swm_pkg::TREE_SH * k))) begin
          for (int b = 0; b < swm_pkg::FANIN; b++) begin
            lvl_d[k][j] = lvl_d[k][j] | lvl_q[k-1][swm_pkg::FANIN * j + b];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
  end

  assign root_o = lvl_q[LVLS][0];

endmodule

/* hdl/stack_with_middle_access.sv */
// Top level: bounded stack with read and delete of the middle entry.
// Uses swm_pkg, swm_cell (one per entry) and swm_or_tree (read-out).
//
//   channel | dir | handshake                 | beat
//   in      | in  | in_valid_i / in_ready_o   | swm_pkg::in_beat_t
//   out     | out | out_valid_o / out_ready_i | swm_pkg::out_beat_t
//
// One request at a time. Cells update at the accept edge; the read-out tree
// then carries the selected value up through its register levels and the
// result register loads the root; in_ready_o rises with the result, and a
// new beat is accepted only after that, never while a read-out is in flight.
// Reset clears the count, phase and handshake state only; cells hold no reset.
// A stalled output holds its beat; the tree root waits until it drains.
module stack_with_middle_access #(
  parameter int DEPTH = swm_pkg::DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  swm_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swm_pkg::out_beat_t  out_data_o
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int LVLS = swm_pkg::tree_lvls(DEPTH);
  localparam int PW   = $clog2(LVLS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_PH  = PW'(LVLS);

  logic                          acc;
  logic                          is_empty, is_full;
  logic [CW-1:0]                 cnt_d, cnt_q;
  logic [CW-1:0]                 mid, sel;
  swm_pkg::cell_ctrl_t           ctrl;
  swm_pkg::status_e              stat_d, stat_q;
  logic                          busy_d, busy_q;
  logic [PW-1:0]                 phase_d, phase_q;
  logic                          done;
  logic                          out_valid_d, out_valid_q;
  swm_pkg::out_beat_t            out_d, out_q;
  logic [swm_pkg::DATA_W-1:0]    root;
  logic [DEPTH-1:0][swm_pkg::DATA_W-1:0] cell_data, shift_in, rd_data;

  assign acc      = in_valid_i && in_ready_o;
  assign is_empty = (cnt_q == '0);
  assign is_full  = (cnt_q == FULL_CNT);
  assign mid      = cnt_q >> 1;

  always_comb begin
    ctrl   = '0;
    cnt_d  = cnt_q;
    stat_d = stat_q;
    sel    = mid;
    if (acc) begin
      stat_d = swm_pkg::ST_OK;
      unique case (in_data_i.func)
        swm_pkg::FUNC_PUSH: begin
          if (is_full) begin
            stat_d = swm_pkg::ST_FULL;
          end else begin
            ctrl.push_en = 1'b1;
            cnt_d        = cnt_q + CW'(1);
          end
        end
        swm_pkg::FUNC_POP: begin
          sel = cnt_q - CW'(1);
          if (is_empty) begin
            stat_d = swm_pkg::ST_EMPTY;
          end else begin
            ctrl.rd_en = 1'b1;
            cnt_d      = cnt_q - CW'(1);
          end
        end
        swm_pkg::FUNC_READ_MID: begin
          if (is_empty) begin
            stat_d = swm_pkg::ST_EMPTY;
          end else begin
            ctrl.rd_en = 1'b1;
          end
        end
        swm_pkg::FUNC_DEL_MID: begin
          if (is_empty) begin
            stat_d = swm_pkg::ST_EMPTY;
          end else begin
            ctrl.del_en = 1'b1;
            cnt_d       = cnt_q - CW'(1);
          end
        end
        default: begin
          stat_d = swm_pkg::ST_OK;
        end
      endcase
    end
  end

  assign shift_in[DEPTH-1] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g < DEPTH - 1) begin : g_link
      assign shift_in[g] = cell_data[g+1];
    end
    swm_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .n_i          (cnt_q),
      .mid_i        (mid),
      .sel_i        (sel),
      .push_value_i (in_data_i.push_value),
      .upper_i      (shift_in[g]),
      .data_o       (cell_data[g]),
      .rd_o         (rd_data[g])
    );
  end

  swm_or_tree #(
    .DEPTH (DEPTH)
  ) u_tree (
    .clk_i    (clk_i),
    .cap_i    (acc),
    .leaves_i (rd_data),
    .root_o   (root)
  );

  assign done = busy_q && (phase_q == LAST_PH) && (!out_valid_q || out_ready_i);

  always_comb begin
    busy_d      = busy_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (acc) begin
      busy_d  = 1'b1;
      phase_d = '0;
    end else if (done) begin
      busy_d             = 1'b0;
      out_valid_d        = 1'b1;
      out_d.result_value = $signed(root);
      out_d.status       = stat_q;
    end else if (busy_q && (phase_q != LAST_PH)) begin
      phase_d = phase_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = !busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("entry count beyond depth");

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> busy_q && (phase_q == '0))
    else $error("accepted beat did not start the read-out");

  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (in_data_i.func == swm_pkg::FUNC_PUSH) && !is_full
      |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("push did not grow the stack");

  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && is_empty && (in_data_i.func != swm_pkg::FUNC_PUSH) |=> $stable(cnt_q))
    else $error("request on empty stack changed the count");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q) && !busy_q)
    else $error("result loaded outside read-out completion");

endmodule
